// ===== hdl/sctc_pkg.sv =====
// ----------------------------------------------------------------------------
// sctc_pkg
// shared types, widths and codes for the sector cache tag controller
// ----------------------------------------------------------------------------
package sctc_pkg;

    localparam int SLOTS        = 64;
    localparam int SECTOR_BYTES = 512;
    localparam int SLOT_W       = $clog2(SLOTS);

    // fixed field widths of the stream items
    localparam int MODE_W    = 2;
    localparam int SECTOR_W  = 32;
    localparam int BYTE_W    = 10;
    localparam int PICK_W    = 6;
    localparam int SLOT_FW   = 6;
    localparam int IN_TDATA_W  = 64;
    localparam int IN_PAD_W    = IN_TDATA_W - (SECTOR_W + 2 * BYTE_W + PICK_W);
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (SLOT_FW + SECTOR_W + 5);

    // request queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // request modes as they arrive
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

    // classified request kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SECTOR_W-1:0] sector;
        logic                full;       // write covers the whole sector
        logic [SLOT_W-1:0]   pick_slot;  // victim slot for a full cache
    } req_t;

    typedef struct packed {
        logic                hit;
        logic [SLOT_FW-1:0]  slot;
        logic                writeback;
        logic [SECTOR_W-1:0] writeback_sector;
        logic                fill_from_disk;
        logic                zero_fill;
        logic                error;
        logic                last;
    } res_t;

    typedef logic [SLOT_W-1:0] pick_tab_t [2**PICK_W];

    function automatic pick_tab_t build_pick_tab();
        pick_tab_t t;
        for (int i = 0; i < 2**PICK_W; i++) begin
            t[i] = SLOT_W'(i % SLOTS);
        end
        return t;
    endfunction

    // random pick folded onto the slot range
    localparam pick_tab_t PICK_TAB = build_pick_tab();

endpackage

// ===== hdl/sector_cache_tag_controller.sv =====
// ----------------------------------------------------------------------------
// sector_cache_tag_controller
// tag and state control for a fully associative write-back sector cache
// ----------------------------------------------------------------------------
//  port group  dir  carries
//  s_*         in   request item: mode in tuser, sector/offset/count/pick in tdata
//  m_*         out  result item: hit, slot, writeback, fill flags, error; tlast
//
//  read or write: back-end steps queue pop, tag compare, slot pick and tag
//  read, result; an error item or a flush with nothing dirty: pop, result
//  after its pop a flush walks one slot a cycle up to the highest dirty slot,
//  with an output step per dirty slot found; the request queue holds two items
//  reset clears valid and dirty bits at once; no clearing pass is needed
//  a stalled output holds the back end, the queue keeps taking requests until full
module sector_cache_tag_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sector[31:0], byte_offset[41:32], byte_count[51:42], victim_pick[57:52]
    input  logic [sctc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // mode[1:0]
    input  logic [sctc_pkg::MODE_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit[0], slot[6:1], writeback[7], writeback_sector[39:8],
    // fill_from_disk[40], zero_fill[41], error[42]
    output logic [sctc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast
);
    import sctc_pkg::*;

    logic q_valid;
    logic q_pop;
    req_t q_req;
    res_t res;

    sctc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop)
    );

    sctc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_req     (q_req),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, res.error, res.zero_fill, res.fill_from_disk,
                      res.writeback_sector, res.writeback, res.slot, res.hit};
    assign m_tlast = res.last;

endmodule

// ===== hdl/sctc_ram.sv =====
// ----------------------------------------------------------------------------
// sctc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module sctc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sctc_front.sv =====
// ----------------------------------------------------------------------------
// sctc_front
// accepts requests, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
module sctc_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sctc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [sctc_pkg::MODE_W-1:0]      s_tuser,
    output logic                             q_valid,
    output sctc_pkg::req_t                   q_req,
    input  logic                             q_pop
);
    import sctc_pkg::*;

    logic [SECTOR_W-1:0] sector;
    logic [BYTE_W-1:0]   byte_offset;
    logic [BYTE_W-1:0]   byte_count;
    logic [PICK_W-1:0]   victim_pick;
    logic [BYTE_W:0]     span;
    logic                range_err;
    req_t                req_in;
    logic                push;

    req_t                q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign sector      = s_tdata[SECTOR_W-1:0];
    assign byte_offset = s_tdata[SECTOR_W +: BYTE_W];
    assign byte_count  = s_tdata[SECTOR_W + BYTE_W +: BYTE_W];
    assign victim_pick = s_tdata[SECTOR_W + 2 * BYTE_W +: PICK_W];

    assign span      = {1'b0, byte_offset} + {1'b0, byte_count};
    assign range_err = 32'(span) > 32'(SECTOR_BYTES);

    always_comb
    begin
        req_in.sector    = sector;
        req_in.full      = (byte_offset == '0) && (32'(byte_count) == 32'(SECTOR_BYTES));
        req_in.pick_slot = PICK_TAB[victim_pick];
        unique case (s_tuser)
            MODE_READ:  req_in.kind = range_err ? KIND_ERR : KIND_READ;
            MODE_WRITE: req_in.kind = range_err ? KIND_ERR : KIND_WRITE;
            MODE_FLUSH: req_in.kind = KIND_FLUSH;
            default:    req_in.kind = KIND_ERR;
        endcase
    end

    assign s_tready = (count_reg != QCNT_W'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_req    = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= req_in;
        end
    end

endmodule

// ===== hdl/sctc_back.sv =====
// ----------------------------------------------------------------------------
// sctc_back
// tag lookup, slot allocation, eviction and flush walk
// ----------------------------------------------------------------------------
module sctc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  sctc_pkg::req_t  q_req,
    output logic            q_pop,
    output logic            res_valid,
    output sctc_pkg::res_t  res,
    input  logic            res_ready
);
    import sctc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ONE   = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_SEL   = 3'd3;
    localparam logic [2:0] ST_RES   = 3'd4;
    localparam logic [2:0] ST_FSCAN = 3'd5;
    localparam logic [2:0] ST_FOUT  = 3'd6;

    logic [2:0]          state_reg, state_next;
    req_t                cmd_reg, cmd_next;
    logic [SLOTS-1:0]    match_reg, match_next;
    logic [SLOTS-1:0]    free_reg, free_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                hit_reg, hit_next;
    logic                evict_reg, evict_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [SLOTS-1:0]    dirty_reg, dirty_next;
    logic                out_valid_reg, out_valid_next;
    res_t                out_reg, out_next;
    logic [SECTOR_W-1:0] tag_reg [SLOTS];

    logic [SLOTS-1:0]    match_c;
    logic [SLOT_W-1:0]   hit_idx, free_idx, sel_slot;
    logic [SLOTS-1:0]    slot_bit;
    logic                out_free;
    logic                is_write;
    logic                tag_we;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [SECTOR_W-1:0] ram_q;

    sctc_ram #(
        .WIDTH (SECTOR_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (slot_reg),
        .wdata (cmd_reg.sector),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // parallel tag compare against every valid slot
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match_c[i] = valid_reg[i] && (tag_reg[i] == cmd_reg.sector);
        end
    end

    // lowest set bit of the registered match and free vectors
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = SLOT_W'(i);
            end
            if (free_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign sel_slot  = (|match_reg) ? hit_idx : ((|free_reg) ? free_idx : cmd_reg.pick_slot);
    assign slot_bit  = SLOTS'(1) << slot_reg;
    assign out_free  = !out_valid_reg || res_ready;
    assign is_write  = (cmd_reg.kind == KIND_WRITE);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign tag_we    = (state_reg == ST_RES) && out_free && !hit_reg;
    assign ram_re    = (state_reg == ST_SEL) || ((state_reg == ST_FSCAN) && dirty_reg[slot_reg]);
    assign ram_raddr = (state_reg == ST_SEL) ? sel_slot : slot_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        match_next     = match_reg;
        free_next      = free_reg;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        evict_next     = evict_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next  = q_req;
                    slot_next = '0;
                    unique case (q_req.kind)
                        KIND_FLUSH: state_next = (dirty_reg == '0) ? ST_ONE : ST_FSCAN;
                        KIND_ERR:   state_next = ST_ONE;
                        default:    state_next = ST_CMP;
                    endcase
                end
            end
            ST_ONE:
            begin
                // error item or flush with nothing dirty
                if (out_free)
                begin
                    out_next       = '0;
                    out_next.error = (cmd_reg.kind == KIND_ERR);
                    out_next.last  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CMP:
            begin
                match_next = match_c;
                free_next  = ~valid_reg;
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                slot_next  = sel_slot;
                hit_next   = |match_reg;
                evict_next = !(|match_reg) && !(|free_reg);
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (out_free)
                begin
                    out_next                  = '0;
                    out_next.hit              = hit_reg;
                    out_next.slot             = SLOT_FW'(slot_reg);
                    out_next.writeback        = evict_reg && dirty_reg[slot_reg];
                    out_next.writeback_sector = (evict_reg && dirty_reg[slot_reg]) ? ram_q : '0;
                    out_next.fill_from_disk   = !hit_reg && !(is_write && cmd_reg.full);
                    out_next.zero_fill        = !hit_reg && is_write && cmd_reg.full;
                    out_next.last             = 1'b1;
                    out_valid_next            = 1'b1;
                    if (!hit_reg)
                    begin
                        valid_next[slot_reg] = 1'b1;
                        dirty_next[slot_reg] = 1'b0;
                    end
                    if (is_write)
                    begin
                        dirty_next[slot_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_FSCAN:
            begin
                // walk one slot a cycle, tag read starts on a dirty one
                if (dirty_reg[slot_reg])
                begin
                    state_next = ST_FOUT;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_FOUT:
            begin
                if (out_free)
                begin
                    out_next                  = '0;
                    out_next.slot             = SLOT_FW'(slot_reg);
                    out_next.writeback        = 1'b1;
                    out_next.writeback_sector = ram_q;
                    // slots below are already clean
                    out_next.last             = ((dirty_reg & ~slot_bit) == '0);
                    out_valid_next            = 1'b1;
                    dirty_next[slot_reg]      = 1'b0;
                    if ((dirty_reg & ~slot_bit) == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_FSCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        match_reg <= match_next;
        free_reg  <= free_next;
        slot_reg  <= slot_next;
        hit_reg   <= hit_next;
        evict_reg <= evict_next;
        out_reg   <= out_next;
        if (tag_we)
        begin
            tag_reg[slot_reg] <= cmd_reg.sector;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
